### src/mrc_pkg.sv
// Shared types, constants and codes for the Modbus RTU response checker.
package mrc_pkg;

   localparam int MAX_FRAME_BYTES = 256;
   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int HDR_BYTES = 6;
   localparam int ADDR_W = 4;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_SLAVE    = 2'd0;
   localparam logic [1:0] REG_FUNCTION = 2'd1;
   localparam logic [1:0] REG_ADDRESS  = 2'd2;
   localparam logic [1:0] REG_COUNT    = 2'd3;

   // Supported function codes.
   localparam logic [7:0] FC_READ_COILS  = 8'd1;
   localparam logic [7:0] FC_READ_REGS   = 8'd3;
   localparam logic [7:0] FC_WRITE_COILS = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS  = 8'd16;
   localparam logic [8:0] EXC_FLAG       = 9'h080;

   localparam logic [7:0] EXC_CODE_MIN = 8'd1;
   localparam logic [7:0] EXC_CODE_MAX = 8'd4;

   localparam logic [12:0] EXC_FRAME_LEN   = 13'd5;
   localparam logic [12:0] WRITE_FRAME_LEN = 13'd8;
   localparam logic [12:0] READ_OVERHEAD   = 13'd5;

   // Status codes.
   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_FORMAT     = 4'd1;
   localparam logic [3:0] ST_CRC        = 4'd2;
   localparam logic [3:0] ST_SLAVE      = 4'd3;
   localparam logic [3:0] ST_FUNCTION   = 4'd4;
   localparam logic [3:0] ST_BAD_EXC    = 4'd5;
   localparam logic [3:0] ST_EXCEPTION  = 4'd6;
   localparam logic [3:0] ST_ADDRESS    = 4'd7;
   localparam logic [3:0] ST_BYTE_COUNT = 4'd8;
   localparam logic [3:0] ST_COUNT      = 4'd9;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0] status;
      logic [7:0] exception_code;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  request_slave;
      logic [7:0]  request_function;
      logic [15:0] request_address;
      logic [10:0] request_count;
   } cfg_type;

   // Frame state as it stands after the current byte is taken in.
   typedef struct packed {
      logic [CNT_W-1:0]           count;
      logic [15:0]                crc;
      logic [HDR_BYTES-1:0][7:0]  hdr;
      logic [7:0]                 trail0;
      logic [7:0]                 trail1;
      logic                       overlong;
   } frame_type;

endpackage

### src/modbus_rtu_response_checker.sv
// Modbus RTU response checker: one status at each frame end.
// The status of a frame is computed from its last byte in the input register and
// loaded into the result register once that is free. Throughput: one byte per
// cycle unless a last byte waits on a stalled result; the per-byte CRC step and
// the frame-end checks each fit in the single stage between the two registers.
// Reset (synchronous, active high) restores the request registers to their
// defaults, empties both registers and starts a new frame.
module modbus_rtu_response_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  mrc_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output mrc_pkg::rsp_type            rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [mrc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   mrc_pkg::cfg_type    cfg;
   mrc_pkg::frame_type  frame;
   mrc_pkg::rsp_type    result;

   logic               in_valid_ff, in_valid_in;
   mrc_pkg::req_type   in_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   mrc_pkg::rsp_type   rsp_data_ff;
   logic               out_free;
   logic               advance;
   logic               load_rsp;
   logic               take_req;

   mrc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mrc_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_data_ff.data_byte),
      .last_byte (in_data_ff.last_byte),
      .frame     (frame)
   );

   mrc_eval u_eval (
      .cfg    (cfg),
      .frame  (frame),
      .result (result)
   );

   // A byte that ends no frame never waits for the result register.
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign advance   = in_valid_ff & (~in_data_ff.last_byte | out_free);
   assign load_rsp  = advance & in_data_ff.last_byte;
   assign req_stall = in_valid_ff & ~advance;
   assign take_req  = req_valid & ~req_stall;

   assign in_valid_in  = take_req | (in_valid_ff & ~advance);
   assign rsp_valid_in = load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) in_data_ff <= req_data;
      if (load_rsp) rsp_data_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/mrc_csr.sv
// Configuration registers holding the outstanding request, on an APB-style port.
module mrc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [mrc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output mrc_pkg::cfg_type            cfg
);

   mrc_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            mrc_pkg::REG_SLAVE:    cfg_in.request_slave    = csr_pwdata[7:0];
            mrc_pkg::REG_FUNCTION: cfg_in.request_function = csr_pwdata[7:0];
            mrc_pkg::REG_ADDRESS:  cfg_in.request_address  = csr_pwdata[15:0];
            mrc_pkg::REG_COUNT:    cfg_in.request_count    = csr_pwdata[10:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.request_slave    <= 8'd1;
         cfg_ff.request_function <= mrc_pkg::FC_READ_REGS;
         cfg_ff.request_address  <= 16'd0;
         cfg_ff.request_count    <= 11'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         mrc_pkg::REG_SLAVE:    csr_prdata = {24'd0, cfg_ff.request_slave};
         mrc_pkg::REG_FUNCTION: csr_prdata = {24'd0, cfg_ff.request_function};
         mrc_pkg::REG_ADDRESS:  csr_prdata = {16'd0, cfg_ff.request_address};
         mrc_pkg::REG_COUNT:    csr_prdata = {21'd0, cfg_ff.request_count};
         default:               csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### src/mrc_frame.sv
// Per-frame state: byte counter, running CRC, header capture and trailing bytes.
module mrc_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   output mrc_pkg::frame_type   frame
);

   logic [mrc_pkg::CNT_W-1:0]              cnt_ff, cnt_in;
   logic [15:0]                            crc_ff, crc_in;
   logic                                   ovl_ff, ovl_in;
   logic [mrc_pkg::HDR_BYTES-1:0][7:0]     hdr_ff;
   logic [7:0]                             trail0_ff, trail1_ff;
   mrc_pkg::frame_type                     upd;

   // One byte of CRC-16/MODBUS, reflected polynomial 0xA001.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) c = (c >> 1) ^ 16'hA001;
         else      c = c >> 1;
      end
      return c;
   endfunction

   always_comb begin
      upd.count    = cnt_ff;
      upd.crc      = crc_ff;
      upd.hdr      = hdr_ff;
      upd.trail0   = trail0_ff;
      upd.trail1   = trail1_ff;
      upd.overlong = ovl_ff;
      if (cnt_ff >= mrc_pkg::CNT_W'(mrc_pkg::MAX_FRAME_BYTES)) begin
         // Bytes past the maximum are dropped; only the flag records them.
         upd.overlong = 1'b1;
      end else begin
         for (int i = 0; i < mrc_pkg::HDR_BYTES; i++) begin
            if (cnt_ff == mrc_pkg::CNT_W'(i)) upd.hdr[i] = data_byte;
         end
         // The CRC trails by two bytes so the received CRC never enters it.
         if (cnt_ff >= mrc_pkg::CNT_W'(2)) upd.crc = crc_byte(crc_ff, trail0_ff);
         upd.trail0 = trail1_ff;
         upd.trail1 = data_byte;
         upd.count  = cnt_ff + mrc_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      crc_in = crc_ff;
      ovl_in = ovl_ff;
      if (step) begin
         if (last_byte) begin
            cnt_in = '0;
            crc_in = 16'hFFFF;
            ovl_in = 1'b0;
         end else begin
            cnt_in = upd.count;
            crc_in = upd.crc;
            ovl_in = upd.overlong;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         crc_ff <= 16'hFFFF;
         ovl_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         crc_ff <= crc_in;
         ovl_ff <= ovl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         hdr_ff    <= upd.hdr;
         trail0_ff <= upd.trail0;
         trail1_ff <= upd.trail1;
      end
   end

   assign frame = upd;

endmodule

### src/mrc_eval.sv
// Frame-end checks in priority order, producing status and exception code.
module mrc_eval (
   input  mrc_pkg::cfg_type    cfg,
   input  mrc_pkg::frame_type  frame,
   output mrc_pkg::rsp_type    result
);

   logic [12:0] expect_len;
   logic [12:0] frame_len;
   logic [11:0] want_bytes;
   logic [11:0] coil_bytes;
   logic [7:0]  func;
   logic [7:0]  code;
   logic        is_read;

   assign frame_len  = 13'(frame.count);
   assign coil_bytes = 12'((12'(cfg.request_count) + 12'd7) >> 3);
   assign func       = frame.hdr[1];
   assign code       = frame.hdr[2];
   assign is_read    = (cfg.request_function == mrc_pkg::FC_READ_COILS) ||
                       (cfg.request_function == mrc_pkg::FC_READ_REGS);
   assign want_bytes = (cfg.request_function == mrc_pkg::FC_READ_COILS) ?
                       coil_bytes : {cfg.request_count, 1'b0};

   always_comb begin
      case (cfg.request_function)
         mrc_pkg::FC_READ_COILS:
            expect_len = 13'(coil_bytes) + mrc_pkg::READ_OVERHEAD;
         mrc_pkg::FC_READ_REGS:
            expect_len = {1'b0, cfg.request_count, 1'b0} + mrc_pkg::READ_OVERHEAD;
         mrc_pkg::FC_WRITE_COILS, mrc_pkg::FC_WRITE_REGS:
            expect_len = mrc_pkg::WRITE_FRAME_LEN;
         default:
            expect_len = 13'd0;
      endcase
   end

   always_comb begin
      result.status         = mrc_pkg::ST_OK;
      result.exception_code = 8'd0;
      if (frame.overlong || expect_len == 13'd0 ||
          (frame_len != expect_len && frame_len != mrc_pkg::EXC_FRAME_LEN)) begin
         result.status = mrc_pkg::ST_FORMAT;
      end else if (frame.crc != {frame.trail1, frame.trail0}) begin
         result.status = mrc_pkg::ST_CRC;
      end else if (frame.hdr[0] != cfg.request_slave) begin
         result.status = mrc_pkg::ST_SLAVE;
      end else if (func == cfg.request_function) begin
         if (frame_len != expect_len) begin
            result.status = mrc_pkg::ST_FORMAT;
         end else if (is_read) begin
            if (12'(code) != want_bytes) result.status = mrc_pkg::ST_BYTE_COUNT;
         end else if ({frame.hdr[2], frame.hdr[3]} != cfg.request_address) begin
            result.status = mrc_pkg::ST_ADDRESS;
         end else if ({frame.hdr[4], frame.hdr[5]} != {5'd0, cfg.request_count}) begin
            result.status = mrc_pkg::ST_COUNT;
         end
      end else if ({1'b0, func} != {1'b0, cfg.request_function} + mrc_pkg::EXC_FLAG) begin
         result.status = mrc_pkg::ST_FUNCTION;
      end else if (frame_len != mrc_pkg::EXC_FRAME_LEN) begin
         result.status = mrc_pkg::ST_FORMAT;
      end else if (code < mrc_pkg::EXC_CODE_MIN || code > mrc_pkg::EXC_CODE_MAX) begin
         result.status = mrc_pkg::ST_BAD_EXC;
      end else begin
         result.status         = mrc_pkg::ST_EXCEPTION;
         result.exception_code = code;
      end
   end

endmodule

### verif/mrc_status_checker.sv
// Frame CRC helper and the monitor that predicts and checks every frame status.
package mrc_tb_pkg;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_SEED = 16'hFFFF;

   // One byte of CRC-16/MODBUS, reflected, least significant bit first.
   function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      int          i;
      c = crc ^ {8'h00, b};
      for (i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

module mrc_status_checker
   import mrc_pkg::*;
   import mrc_tb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic              csr_pready,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output int                failures,
   output int                pending
);

   // Our own copy of the request registers.
   logic [7:0]  cfg_slave;
   logic [7:0]  cfg_function;
   logic [15:0] cfg_address;
   logic [10:0] cfg_count;

   // Frame being received.
   logic [8:0]  rx_count;
   logic [15:0] rx_crc;
   logic [7:0]  rx_head [HDR_BYTES];
   logic [7:0]  rx_tail [2];
   logic        rx_overlong;

   rsp_type     awaited_status [$];
   int          mismatches = 0;

   task automatic start_frame();
      int i;
      rx_count = '0;
      rx_crc = CRC_SEED;
      for (i = 0; i < HDR_BYTES; i++) rx_head[i] = 8'h00;
      rx_tail[0] = 8'h00;
      rx_tail[1] = 8'h00;
      rx_overlong = 1'b0;
   endtask

   // Status of the frame just completed; checks are taken in priority order.
   function automatic rsp_type frame_verdict();
      rsp_type verdict;
      int      n;
      int      norm_len;
      int      want;
      verdict.status = ST_OK;
      verdict.exception_code = 8'h00;
      n = int'(rx_count);
      case (cfg_function)
         FC_READ_COILS:                 norm_len = (int'(cfg_count) + 7) / 8 + int'(READ_OVERHEAD);
         FC_READ_REGS:                  norm_len = int'(cfg_count) * 2 + int'(READ_OVERHEAD);
         FC_WRITE_COILS, FC_WRITE_REGS: norm_len = int'(WRITE_FRAME_LEN);
         default:                       norm_len = 0;
      endcase
      if (rx_overlong || norm_len == 0 || (n != norm_len && n != int'(EXC_FRAME_LEN))) begin
         verdict.status = ST_FORMAT;
      end else if (rx_crc != {rx_tail[1], rx_tail[0]}) begin
         verdict.status = ST_CRC;
      end else if (rx_head[0] != cfg_slave) begin
         verdict.status = ST_SLAVE;
      end else if (rx_head[1] == cfg_function) begin
         if (n != norm_len) begin
            verdict.status = ST_FORMAT;
         end else if (cfg_function == FC_READ_COILS || cfg_function == FC_READ_REGS) begin
            want = (cfg_function == FC_READ_COILS) ? (int'(cfg_count) + 7) / 8
                                                   : int'(cfg_count) * 2;
            if (int'(rx_head[2]) != want) verdict.status = ST_BYTE_COUNT;
         end else if ({rx_head[2], rx_head[3]} != cfg_address) begin
            verdict.status = ST_ADDRESS;
         end else if ({rx_head[4], rx_head[5]} != 16'(cfg_count)) begin
            verdict.status = ST_COUNT;
         end
      end else if (int'(rx_head[1]) != int'(cfg_function) + int'(EXC_FLAG)) begin
         verdict.status = ST_FUNCTION;
      end else if (n != int'(EXC_FRAME_LEN)) begin
         verdict.status = ST_FORMAT;
      end else if (rx_head[2] < EXC_CODE_MIN || rx_head[2] > EXC_CODE_MAX) begin
         verdict.status = ST_BAD_EXC;
      end else begin
         verdict.status = ST_EXCEPTION;
         verdict.exception_code = rx_head[2];
      end
      return verdict;
   endfunction

   always @(posedge clock) begin
      rsp_type oldest;
      if (reset) begin
         cfg_slave = 8'd1;
         cfg_function = FC_READ_REGS;
         cfg_address = 16'd0;
         cfg_count = 11'd1;
         start_frame();
         awaited_status.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[ADDR_W-1:2])
               REG_SLAVE:    cfg_slave = csr_pwdata[7:0];
               REG_FUNCTION: cfg_function = csr_pwdata[7:0];
               REG_ADDRESS:  cfg_address = csr_pwdata[15:0];
               REG_COUNT:    cfg_count = csr_pwdata[10:0];
               default:      ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (awaited_status.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result: status %0d exception_code %0d",
                           rsp_data.status, rsp_data.exception_code);
            end else begin
               oldest = awaited_status.pop_front();
               if (rsp_data.status != oldest.status ||
                   rsp_data.exception_code != oldest.exception_code) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected status %0d exception_code %0d, got %0d %0d",
                              oldest.status, oldest.exception_code,
                              rsp_data.status, rsp_data.exception_code);
               end
            end
         end

         if (req_valid && !req_stall) begin
            // Bytes past the maximum are dropped; only the overlong mark is kept.
            if (rx_count >= MAX_FRAME_BYTES) begin
               rx_overlong = 1'b1;
            end else begin
               if (rx_count < HDR_BYTES) rx_head[rx_count] = req_data.data_byte;
               if (rx_count >= 2) rx_crc = crc16_step(rx_crc, rx_tail[0]);
               rx_tail[0] = rx_tail[1];
               rx_tail[1] = req_data.data_byte;
               rx_count = rx_count + 9'd1;
            end
            if (req_data.last_byte) begin
               awaited_status.push_back(frame_verdict());
               start_frame();
            end
         end
      end
      failures <= mismatches;
      pending <= awaited_status.size();
   end

endmodule

### verif/modbus_rtu_response_checker_tb.sv
// Top of the testbench: clock, reset, response frame stimulus and the final verdict.
module modbus_rtu_response_checker_tb;
   import mrc_pkg::*;
   import mrc_tb_pkg::*;

   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          BYTE_TARGET = 1150;
   localparam int          CALM_BYTES = 980;
   localparam logic [7:0]  FC_UNSUPPORTED = 8'hFF;

   typedef enum {
      FR_GOOD, FR_EXC, FR_BAD_CODE, FR_BAD_CRC, FR_BAD_SLAVE, FR_BAD_FUNC,
      FR_BAD_FIELD, FR_BAD_LEN, FR_NOISE, FR_OVERLONG
   } frame_kind_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;
   int                failures;
   int                pending;

   // Stimulus side view of the request registers, used to build frames.
   logic [7:0]        tb_slave = 8'd1;
   logic [7:0]        tb_function = FC_READ_REGS;
   logic [15:0]       tb_address = 16'd0;
   logic [10:0]       tb_count = 11'd1;

   logic [7:0]        frame_buf [$];
   bit                calm = 1'b0;
   bit                busy_req = 1'b1;
   bit                busy_rsp = 1'b1;
   int                bytes_sent = 0;
   int                frames_sent = 0;
   int                settings_used = 0;
   int                idle_cycles = 0;
   int                stall_left = 0;

   modbus_rtu_response_checker dut (.*);

   mrc_status_checker watcher (.*);

   always #4 clock = ~clock;

   // Result side back-pressure in short bursts.
   always @(negedge clock) begin
      if (calm || !busy_rsp) begin
         rsp_stall = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without progress", idle_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = ADDR_W'({index, 2'b00});
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Upper bits beyond each register's width are sometimes filled with junk.
   task automatic apply_setting(logic [7:0] s, logic [7:0] f, logic [15:0] a, logic [10:0] c);
      logic [31:0] junk;
      junk = $urandom_range(0, 1) ? $urandom : 32'd0;
      tb_slave = s;
      tb_function = f;
      tb_address = a;
      tb_count = c;
      csr_write(REG_SLAVE, {junk[31:8], s});
      csr_write(REG_FUNCTION, {junk[23:0], f});
      csr_write(REG_ADDRESS, {junk[15:0], a});
      csr_write(REG_COUNT, {junk[20:0], c});
      settings_used++;
   endtask

   // Drop the request valid and let every pending frame status come out.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      // The tail of the run goes without any idling on either side.
      if (bytes_sent >= CALM_BYTES) calm = 1'b1;
      gap = (!calm && busy_req && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = '{data_byte: b, last_byte: last};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_frame(frame_kind_type kind);
      int          n_data;
      int          len;
      int          i;
      bit          exc_base;
      logic [15:0] crc;
      frame_buf.delete();
      if (kind == FR_NOISE || kind == FR_OVERLONG) begin
         len = (kind == FR_NOISE) ? $urandom_range(1, 12) : $urandom_range(257, 262);
         repeat (len) frame_buf.push_back(8'($urandom));
      end else begin
         exc_base = (kind == FR_EXC || kind == FR_BAD_CODE ||
                     (kind == FR_BAD_LEN && $urandom_range(0, 1) == 1));
         frame_buf.push_back(tb_slave);
         if (exc_base) begin
            frame_buf.push_back(tb_function + 8'h80);
            if (kind == FR_BAD_CODE)
               frame_buf.push_back($urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(5, 255)));
            else
               frame_buf.push_back(8'($urandom_range(1, 4)));
         end else begin
            frame_buf.push_back(tb_function);
            if (tb_function == FC_WRITE_COILS || tb_function == FC_WRITE_REGS) begin
               frame_buf.push_back(tb_address[15:8]);
               frame_buf.push_back(tb_address[7:0]);
               frame_buf.push_back({5'd0, tb_count[10:8]});
               frame_buf.push_back(tb_count[7:0]);
            end else begin
               if (tb_function == FC_READ_COILS) n_data = (int'(tb_count) + 7) / 8;
               else if (tb_function == FC_READ_REGS) n_data = int'(tb_count) * 2;
               else n_data = $urandom_range(0, 6);
               if (n_data > 251) n_data = $urandom_range(0, 6);
               frame_buf.push_back(8'(n_data));
               repeat (n_data) frame_buf.push_back(8'($urandom));
            end
         end

         case (kind)
            FR_BAD_SLAVE: frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
            FR_BAD_FUNC:  frame_buf[1] = 8'($urandom);
            FR_BAD_FIELD: begin
               i = $urandom_range(2, frame_buf.size() - 1);
               frame_buf[i] = frame_buf[i] ^ (8'd1 << $urandom_range(0, 7));
            end
            FR_BAD_LEN: begin
               // A cut to three bytes gives a frame of the exception length.
               if ($urandom_range(0, 2) == 0) begin
                  while (frame_buf.size() > 3) void'(frame_buf.pop_back());
               end else if ($urandom_range(0, 1) == 1) begin
                  repeat ($urandom_range(1, 2))
                     if (frame_buf.size() > 1) void'(frame_buf.pop_back());
               end else begin
                  repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom));
               end
            end
            default: ;
         endcase

         crc = CRC_SEED;
         foreach (frame_buf[j]) crc = crc16_step(crc, frame_buf[j]);
         frame_buf.push_back(crc[7:0]);
         frame_buf.push_back(crc[15:8]);
         if (kind == FR_BAD_CRC) begin
            i = frame_buf.size() - 1 - $urandom_range(0, 1);
            frame_buf[i] = frame_buf[i] ^ (8'd1 << $urandom_range(0, 7));
         end
      end

      for (i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
      frames_sent++;
   endtask

   initial begin
      int             roll;
      int             frames;
      frame_kind_type kind;
      logic [7:0]     s;
      logic [7:0]     f;
      logic [15:0]    a;
      logic [10:0]    c;

      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed frames, starting from the reset values of the request registers.
      send_frame(FR_GOOD);
      send_frame(FR_EXC);
      send_frame(FR_BAD_CRC);
      settle();
      apply_setting(8'd255, FC_WRITE_REGS, 16'hFFFF, 11'd2000);
      send_frame(FR_GOOD);
      send_frame(FR_BAD_FIELD);
      send_frame(FR_BAD_CODE);
      settle();
      apply_setting(8'd0, FC_WRITE_COILS, 16'h0000, 11'd0);
      send_frame(FR_GOOD);
      send_frame(FR_BAD_SLAVE);
      send_frame(FR_BAD_LEN);
      settle();
      // A read of zero coils is exactly as long as an exception frame.
      apply_setting(8'd1, FC_READ_COILS, 16'h1234, 11'd0);
      send_frame(FR_GOOD);
      send_frame(FR_BAD_FUNC);
      send_frame(FR_EXC);
      settle();
      apply_setting(8'd7, FC_UNSUPPORTED, 16'h8000, 11'd5);
      send_frame(FR_GOOD);
      send_frame(FR_EXC);
      settle();
      apply_setting(8'd255, FC_READ_COILS, 16'hFFFF, 11'd2000);
      send_frame(FR_GOOD);
      send_frame(FR_OVERLONG);
      send_frame(FR_NOISE);

      while (bytes_sent < BYTE_TARGET) begin
         settle();
         calm = (bytes_sent >= CALM_BYTES);
         busy_req = ($urandom_range(0, 3) != 0);
         busy_rsp = ($urandom_range(0, 3) != 0);

         roll = $urandom_range(0, 99);
         s = (roll < 25) ? ((roll < 12) ? 8'd0 : 8'd255) : 8'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 22) f = FC_READ_COILS;
         else if (roll < 50) f = FC_READ_REGS;
         else if (roll < 68) f = FC_WRITE_COILS;
         else if (roll < 86) f = FC_WRITE_REGS;
         else f = 8'($urandom);
         roll = $urandom_range(0, 99);
         a = (roll < 20) ? ((roll < 10) ? 16'h0000 : 16'hFFFF) : 16'($urandom);
         case (f)
            FC_READ_REGS:
               c = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 130))
                                               : 11'($urandom_range(0, 8));
            FC_READ_COILS:
               c = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2000))
                                               : 11'($urandom_range(0, 64));
            default: begin
               c = 11'($urandom_range(0, 2000));
               if ($urandom_range(0, 4) == 0) c = $urandom_range(0, 1) ? 11'd0 : 11'd2000;
            end
         endcase
         apply_setting(s, f, a, c);

         // Long read responses get only a couple of frames per setting.
         if ((f == FC_READ_COILS && c > 64) || (f == FC_READ_REGS && c > 8))
            frames = 2;
         else
            frames = $urandom_range(4, 10);
         repeat (frames) begin
            roll = $urandom_range(0, 99);
            if (roll < 38) kind = FR_GOOD;
            else if (roll < 52) kind = FR_EXC;
            else if (roll < 58) kind = FR_BAD_CODE;
            else if (roll < 66) kind = FR_BAD_CRC;
            else if (roll < 72) kind = FR_BAD_SLAVE;
            else if (roll < 78) kind = FR_BAD_FUNC;
            else if (roll < 87) kind = FR_BAD_FIELD;
            else if (roll < 93) kind = FR_BAD_LEN;
            else if (roll < 99) kind = FR_NOISE;
            else kind = FR_OVERLONG;
            send_frame(kind);
         end
      end
      settle();
      repeat (8) @(posedge clock);

      $display("Checked the status of %0d response frames (%0d bytes) under %0d request settings.",
               frames_sent, bytes_sent, settings_used);
      if (failures == 0 && pending == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
src/mrc_pkg.sv
src/mrc_csr.sv
src/mrc_frame.sv
src/mrc_eval.sv
src/modbus_rtu_response_checker.sv
verif/mrc_status_checker.sv
verif/modbus_rtu_response_checker_tb.sv
